>>> sv/assert_macros.svh
// Assertion macros shared by the CRC engine RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent checked in the clock after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ntcrc64_pkg.sv
// Types, constants and helpers for the nibble table CRC-64 engine.
// No dependencies.
package ntcrc64_pkg;

  localparam int CRC_W      = 64;
  localparam int BYTE_W     = 8;
  localparam int NIB_BITS   = 4;
  localparam int TBL_DEPTH  = 16;
  localparam int TBL_IDX_W  = 4;
  localparam int TOP_W      = 7;
  localparam int SHIFT_W    = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TBL_IDX_W-1:0] NIB_MASK = 4'hf;
  localparam logic [TOP_W-1:0]     TOP_MAX  = 7'd64;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_BIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT    = 1'd1;

  typedef struct packed {
    logic                  req_type;
    logic [BYTE_W-1:0]     msg_byte;
    logic                  first_byte;
    logic                  last_byte;
    logic [TBL_IDX_W-1:0]  table_index;
    logic [CRC_W-1:0]      table_word;
  } item_t;

  typedef struct packed {
    logic                  tbl_we;
    logic [TBL_IDX_W-1:0]  tbl_idx;
    logic                  reflected;
    logic [SHIFT_W-1:0]    shift;
  } fold_ctrl_t;

  // Forward mode: bit position of the indexed nibble, saturated to 0..60.
  function automatic logic [SHIFT_W-1:0] shift_amount(input logic [TOP_W-1:0] top);
    logic [TOP_W-1:0] t;
    t = (top > TOP_MAX) ? TOP_MAX : top;
    if (t >= TOP_W'(NIB_BITS)) begin
      return SHIFT_W'(t - TOP_W'(NIB_BITS));
    end
    return '0;
  endfunction

endpackage

>>> sv/ntcrc64_fold.sv
// Nibble table storage and the two chained nibble lookups for one byte.
// Depends on ntcrc64_pkg.
module ntcrc64_fold (
  input  logic                                       clk,
  input  ntcrc64_pkg::fold_ctrl_t                    ctrl,
  input  logic [ntcrc64_pkg::CRC_W-1:0]              tbl_word,
  input  logic [ntcrc64_pkg::CRC_W-1:0]              crc_in,
  input  logic [ntcrc64_pkg::BYTE_W-1:0]             data_in,
  output logic [ntcrc64_pkg::CRC_W-1:0]              crc_out
);

  logic [ntcrc64_pkg::CRC_W-1:0]     tbl [ntcrc64_pkg::TBL_DEPTH];
  logic [ntcrc64_pkg::TBL_IDX_W-1:0] idx0;
  logic [ntcrc64_pkg::TBL_IDX_W-1:0] idx1;
  logic [ntcrc64_pkg::CRC_W-1:0]     crc_mid;
  logic [ntcrc64_pkg::CRC_W-1:0]     sel0;
  logic [ntcrc64_pkg::CRC_W-1:0]     sel1;

  always_ff @(posedge clk) begin
    if (ctrl.tbl_we) begin
      tbl[ctrl.tbl_idx] <= tbl_word;
    end
  end

  // Reflected: low nibble first, shift right. Forward: high nibble first, shift left.
  always_comb begin
    sel0 = crc_in >> ctrl.shift;
    if (ctrl.reflected) begin
      idx0    = (crc_in[3:0] ^ data_in[3:0]) & ntcrc64_pkg::NIB_MASK;
      crc_mid = tbl[idx0] ^ (crc_in >> ntcrc64_pkg::NIB_BITS);
    end else begin
      idx0    = (sel0[3:0] ^ data_in[7:4]) & ntcrc64_pkg::NIB_MASK;
      crc_mid = tbl[idx0] ^ (crc_in << ntcrc64_pkg::NIB_BITS);
    end
    sel1 = crc_mid >> ctrl.shift;
    if (ctrl.reflected) begin
      idx1    = (crc_mid[3:0] ^ data_in[7:4]) & ntcrc64_pkg::NIB_MASK;
      crc_out = tbl[idx1] ^ (crc_mid >> ntcrc64_pkg::NIB_BITS);
    end else begin
      idx1    = (sel1[3:0] ^ data_in[3:0]) & ntcrc64_pkg::NIB_MASK;
      crc_out = tbl[idx1] ^ (crc_mid << ntcrc64_pkg::NIB_BITS);
    end
  end

endmodule

>>> sv/nibble_table_crc64_engine.sv
// An accepted word is registered into the stage and folds into the CRC when the stage advances;
// a last byte's CRC is then registered into crc_value and held until taken.
// Throughput: one word per cycle, both nibble lookups in one fold stage; in_ready
// drops only while a last byte waits behind an untaken result, then follows out_ready.
// Reset (synchronous, active high) clears the CRC, configuration and valids;
// the nibble table is not cleared and must be written before it is read.
module nibble_table_crc64_engine (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [ntcrc64_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ntcrc64_pkg::CRC_W-1:0]           cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    req_type,
  input  logic [ntcrc64_pkg::BYTE_W-1:0]          msg_byte,
  input  logic                                    first_byte,
  input  logic                                    last_byte,
  input  logic [ntcrc64_pkg::TBL_IDX_W-1:0]       table_index,
  input  logic [ntcrc64_pkg::CRC_W-1:0]           table_word,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [ntcrc64_pkg::CRC_W-1:0]           crc_value
);

  `include "assert_macros.svh"

  logic [ntcrc64_pkg::TOP_W-1:0] top_bit_position;
  logic [ntcrc64_pkg::CRC_W-1:0] initial_value;
  logic [ntcrc64_pkg::CRC_W-1:0] running_crc;
  ntcrc64_pkg::item_t            stage;
  logic                          stage_valid;

  logic                          is_data;
  logic                          has_result;
  logic                          advance;
  logic                          out_load;
  logic [ntcrc64_pkg::CRC_W-1:0] crc_base;
  logic [ntcrc64_pkg::CRC_W-1:0] crc_next;
  ntcrc64_pkg::fold_ctrl_t       fold_ctrl;

  assign is_data    = (stage.req_type == ntcrc64_pkg::REQ_DATA);
  assign has_result = is_data && stage.last_byte;
  assign advance    = stage_valid && (!has_result || !out_valid || out_ready);
  assign out_load   = advance && has_result;
  assign in_ready   = !stage_valid || advance;
  assign crc_base   = stage.first_byte ? initial_value : running_crc;

  assign fold_ctrl.tbl_we    = advance && (stage.req_type == ntcrc64_pkg::REQ_TABLE);
  assign fold_ctrl.tbl_idx   = stage.table_index;
  assign fold_ctrl.reflected = (top_bit_position == '0);
  assign fold_ctrl.shift     = ntcrc64_pkg::shift_amount(top_bit_position);

  ntcrc64_fold u_fold (
    .clk      (clk),
    .ctrl     (fold_ctrl),
    .tbl_word (stage.table_word),
    .crc_in   (crc_base),
    .data_in  (stage.msg_byte),
    .crc_out  (crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top_bit_position <= '0;
      initial_value    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ntcrc64_pkg::CFG_TOP_BIT: top_bit_position <= cfg_data[ntcrc64_pkg::TOP_W-1:0];
        ntcrc64_pkg::CFG_INIT:    initial_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage.req_type    <= req_type;
      stage.msg_byte    <= msg_byte;
      stage.first_byte  <= first_byte;
      stage.last_byte   <= last_byte;
      stage.table_index <= table_index;
      stage.table_word  <= table_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (advance && is_data) begin
      running_crc <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      crc_value <= crc_next;
    end
  end

  `ASSERT_ALWAYS(a_empty_stage_ready, !stage_valid |-> in_ready, "empty stage not ready")
  `ASSERT_ALWAYS(a_load_only_last, out_load |-> (is_data && stage.last_byte), "bad result load")
  `ASSERT_NEXT(a_stall_holds_crc, stage_valid && !advance, $stable(running_crc), "crc moved in stall")
  `ASSERT_NEXT(a_table_keeps_crc, advance && !is_data, $stable(running_crc), "table write moved crc")

endmodule

>>> tb/nibble_table_crc64_engine_tb.sv
// Self-checking testbench for nibble_table_crc64_engine: random and directed words,
// predicted CRCs compared in order against crc_value. Depends on ntcrc64_pkg.
`timescale 1ns / 1ps

module nibble_table_crc64_engine_tb;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [ntcrc64_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [ntcrc64_pkg::CRC_W-1:0]       cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                req_type = ntcrc64_pkg::REQ_DATA;
  logic [ntcrc64_pkg::BYTE_W-1:0]      msg_byte = '0;
  logic                                first_byte = 1'b0;
  logic                                last_byte = 1'b0;
  logic [ntcrc64_pkg::TBL_IDX_W-1:0]   table_index = '0;
  logic [ntcrc64_pkg::CRC_W-1:0]       table_word = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [ntcrc64_pkg::CRC_W-1:0]       crc_value;

  nibble_table_crc64_engine uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .msg_byte(msg_byte), .first_byte(first_byte),
    .last_byte(last_byte), .table_index(table_index), .table_word(table_word),
    .out_valid(out_valid), .out_ready(out_ready), .crc_value(crc_value)
  );

  ntcrc64_pkg::item_t               word_queue[$];
  logic [ntcrc64_pkg::CRC_W-1:0]    crc_expect[$];
  logic                             in_taken = 1'b0;
  int                               send_idle_pct = 0;
  int                               recv_stall_pct = 0;
  logic                             rcv_hold = 1'b0;
  logic                             hold_start = 1'b0;
  int                               err_count = 0;

  logic [ntcrc64_pkg::CRC_W-1:0]    tbl_copy [ntcrc64_pkg::TBL_DEPTH];
  logic [ntcrc64_pkg::TOP_W-1:0]    top_copy = '0;
  logic [ntcrc64_pkg::CRC_W-1:0]    init_copy = '0;
  logic [ntcrc64_pkg::CRC_W-1:0]    crc_copy = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("nibble_table_crc64_engine_tb failed");
    $finish;
  end

  // long receiver hold, counted here while the sender keeps going
  initial begin
    wait (hold_start);
    rcv_hold = 1'b1;
    repeat (300) @(posedge clk);
    rcv_hold = 1'b0;
  end

  function automatic logic [ntcrc64_pkg::CRC_W-1:0] fold_byte(
      input logic [ntcrc64_pkg::CRC_W-1:0] c,
      input logic [ntcrc64_pkg::BYTE_W-1:0] b);
    logic [ntcrc64_pkg::SHIFT_W-1:0] sh;
    if (top_copy == '0) begin
      c = tbl_copy[c[3:0] ^ b[3:0]] ^ (c >> ntcrc64_pkg::NIB_BITS);
      c = tbl_copy[c[3:0] ^ b[7:4]] ^ (c >> ntcrc64_pkg::NIB_BITS);
    end else begin
      if (top_copy > 7'd64) begin
        sh = 6'd60;
      end else if (top_copy >= 7'd4) begin
        sh = ntcrc64_pkg::SHIFT_W'(top_copy - 7'd4);
      end else begin
        sh = '0;
      end
      c = tbl_copy[4'(c >> sh) ^ b[7:4]] ^ (c << ntcrc64_pkg::NIB_BITS);
      c = tbl_copy[4'(c >> sh) ^ b[3:0]] ^ (c << ntcrc64_pkg::NIB_BITS);
    end
    return c;
  endfunction

  function automatic void predict_word(input ntcrc64_pkg::item_t w);
    if (w.req_type == ntcrc64_pkg::REQ_TABLE) begin
      tbl_copy[w.table_index] = w.table_word;
    end else begin
      if (w.first_byte) crc_copy = init_copy;
      crc_copy = fold_byte(crc_copy, w.msg_byte);
      if (w.last_byte) crc_expect.push_back(crc_copy);
    end
  endfunction

  function automatic logic [ntcrc64_pkg::CRC_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [ntcrc64_pkg::BYTE_W-1:0] rand_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return ntcrc64_pkg::BYTE_W'($urandom());
  endfunction

  function automatic ntcrc64_pkg::item_t data_item(input logic [ntcrc64_pkg::BYTE_W-1:0] b,
                                                   input logic f, input logic l);
    ntcrc64_pkg::item_t w;
    w.req_type    = ntcrc64_pkg::REQ_DATA;
    w.msg_byte    = b;
    w.first_byte  = f;
    w.last_byte   = l;
    w.table_index = ntcrc64_pkg::TBL_IDX_W'($urandom());
    w.table_word  = rand64();
    return w;
  endfunction

  function automatic ntcrc64_pkg::item_t table_item(
      input logic [ntcrc64_pkg::TBL_IDX_W-1:0] idx,
      input logic [ntcrc64_pkg::CRC_W-1:0] val);
    ntcrc64_pkg::item_t w;
    w.req_type    = ntcrc64_pkg::REQ_TABLE;
    w.msg_byte    = ntcrc64_pkg::BYTE_W'($urandom());
    w.first_byte  = 1'($urandom());
    w.last_byte   = 1'($urandom());
    w.table_index = idx;
    w.table_word  = val;
    return w;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_type    <= word_queue[0].req_type;
        msg_byte    <= word_queue[0].msg_byte;
        first_byte  <= word_queue[0].first_byte;
        last_byte   <= word_queue[0].last_byte;
        table_index <= word_queue[0].table_index;
        table_word  <= word_queue[0].table_word;
        void'(word_queue.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rcv_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    ntcrc64_pkg::item_t seen;
    logic [ntcrc64_pkg::CRC_W-1:0] want;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (crc_expect.size() == 0) begin
        flag_error($sformatf("unexpected crc_value %h", crc_value));
      end else begin
        want = crc_expect.pop_front();
        if (crc_value !== want)
          flag_error($sformatf("crc_value mismatch: expected %h, got %h", want, crc_value));
      end
    end
    if (!rst && in_valid && in_ready) begin
      seen.req_type    = req_type;
      seen.msg_byte    = msg_byte;
      seen.first_byte  = first_byte;
      seen.last_byte   = last_byte;
      seen.table_index = table_index;
      seen.table_word  = table_word;
      predict_word(seen);
    end
  end

  task automatic wait_idle();
    while (word_queue.size() != 0 || in_valid || crc_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ntcrc64_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ntcrc64_pkg::CRC_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ntcrc64_pkg::CFG_TOP_BIT) begin
      top_copy = val[ntcrc64_pkg::TOP_W-1:0];
    end else begin
      init_copy = val;
    end
  endtask

  task automatic queue_random(input int n);
    int added;
    int kind;
    int len;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        word_queue.push_back(table_item(ntcrc64_pkg::TBL_IDX_W'($urandom()), rand64()));
        added++;
      end else if (kind < 25) begin
        word_queue.push_back(data_item(rand_byte(), 1'($urandom()), 1'($urandom())));
        added++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) begin
            word_queue.push_back(table_item(ntcrc64_pkg::TBL_IDX_W'($urandom()), rand64()));
            added++;
          end
          word_queue.push_back(data_item(rand_byte(), i == 0, i == len - 1));
          added++;
        end
      end
    end
  endtask

  initial begin
    logic [ntcrc64_pkg::TOP_W-1:0] top_list [8];
    logic [ntcrc64_pkg::CRC_W-1:0] init_val;
    top_list = '{7'd0, 7'd1, 7'd3, 7'd4, 7'd64, 7'd127, 7'd0, 7'd0};
    top_list[6] = ntcrc64_pkg::TOP_W'($urandom_range(5, 63));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table before any lookup
    for (int i = 0; i < ntcrc64_pkg::TBL_DEPTH; i++) begin
      word_queue.push_back(table_item(ntcrc64_pkg::TBL_IDX_W'(i),
                                      (i == 0) ? '0 : (i == 15) ? '1 : rand64()));
    end
    // no first flag since reset, then first and last together
    word_queue.push_back(data_item(8'h00, 1'b0, 1'b0));
    word_queue.push_back(data_item(8'hff, 1'b0, 1'b1));
    word_queue.push_back(data_item(8'ha5, 1'b1, 1'b1));
    // table write in the middle of a message, data fields all set
    word_queue.push_back(data_item(8'h00, 1'b1, 1'b0));
    begin
      ntcrc64_pkg::item_t w;
      w = table_item(4'hf, '1);
      w.msg_byte   = 8'hff;
      w.first_byte = 1'b1;
      w.last_byte  = 1'b1;
      word_queue.push_back(w);
    end
    word_queue.push_back(data_item(8'hff, 1'b0, 1'b1));

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      init_val = (p == 0) ? '1 : (p == 3) ? '0 : rand64();
      write_reg(ntcrc64_pkg::CFG_TOP_BIT, ntcrc64_pkg::CRC_W'(top_list[p]));
      write_reg(ntcrc64_pkg::CFG_INIT, init_val);
      @(posedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      word_queue.push_back(data_item(8'h00, 1'b1, 1'b1));
      word_queue.push_back(data_item(8'hff, 1'b1, 1'b1));
      queue_random(50);
      if (p == 4) begin
        // output blocked while input keeps coming
        repeat (3) @(posedge clk);
        hold_start = 1'b1;
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0 && crc_expect.size() == 0) begin
      $display("nibble_table_crc64_engine_tb passed");
    end else begin
      $display("nibble_table_crc64_engine_tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/ntcrc64_pkg.sv
sv/ntcrc64_fold.sv
sv/nibble_table_crc64_engine.sv
tb/nibble_table_crc64_engine_tb.sv
